>>> sv/fcf_pkg.sv
// Shared constants and helper functions for the fast float32 cosine unit.
`timescale 1ns / 1ps
package fcf_pkg;

  localparam logic [31:0] SignBit    = 32'h8000_0000;
  localparam logic [31:0] InfBits    = 32'h7F80_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [31:0] DefaultNan = 32'h7FC0_0000;
  localparam logic [31:0] PiHi       = 32'h4049_0FDB;
  localparam logic [31:0] PiLo       = 32'hB3BB_BD2E;
  localparam logic [31:0] InvPi      = 32'h3EA2_F983;
  localparam logic [31:0] Coef0      = 32'hBE2A_2982;
  localparam logic [31:0] Coef1      = 32'h3BFB_98C3;
  localparam logic [31:0] RangeLimit = 32'h4700_0000;
  localparam logic [31:0] HalfBits   = 32'h3F00_0000;
  localparam logic [31:0] MHalfBits  = 32'hBF00_0000;
  localparam logic [31:0] OneBits    = 32'h3F80_0000;
  localparam logic [31:0] MZeroBits  = 32'h8000_0000;
  localparam logic [31:0] SatBits    = 32'h4F00_0000;

  // valid stages ahead of the output register
  localparam int unsigned PipeDepth = 36;

  function automatic logic is_nan(input logic [31:0] v);
    return v[30:0] > InfBits[30:0];
  endfunction

  // Index of the highest set bit, zero for an all-zero word.
  function automatic logic [5:0] msb64(input logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  // Round to integral, ties away from zero.
  function automatic logic [31:0] round_away(input logic [31:0] v);
    logic [31:0] ax;
    logic [7:0]  be;
    logic [4:0]  k;
    ax = {1'b0, v[30:0]};
    be = ax[30:23];
    k  = 5'(8'd150 - be);
    if (is_nan(v)) return v | QuietBit;
    if (be >= 8'd150) return v;
    if (be < 8'd126) return {v[31], 31'b0};
    if (be == 8'd126) return {v[31], OneBits[30:0]};
    ax = ax + (32'd1 << (k - 5'd1));
    ax = ax & ~((32'd1 << k) - 32'd1);
    return {v[31], ax[30:0]};
  endfunction

  // Parity of the saturating int32 conversion, placed at bit 31.
  function automatic logic [31:0] odd_mask(input logic [31:0] n);
    logic [7:0]  be;
    logic [23:0] m;
    logic [4:0]  sh;
    be = n[30:23];
    m  = {1'b1, n[22:0]};
    sh = 5'(8'd150 - be);
    if (is_nan(n)) return '0;
    if ({1'b0, n[30:0]} >= SatBits) return n[31] ? 32'd0 : SignBit;
    if (be < 8'd127 || be > 8'd150) return '0;
    return {((m >> sh) & 24'd1) != 24'd0, 31'b0};
  endfunction

endpackage

>>> sv/fcf_fma.sv
// Five-stage pipelined float32 fused multiply-add, round to nearest even.
`timescale 1ns / 1ps
module fcf_fma (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  output logic [31:0] z_o
);

  typedef struct packed {
    logic        hit;
    logic [31:0] val;
  } spec_t;

  // stage 1: specials, unpack, multiply
  logic        sp, sc;
  logic [30:0] aa, ab, ac;
  spec_t       s1_spec_d;
  logic [23:0] ma, mb, mc;
  logic signed [11:0] ea, eb, ec;

  assign sp = a_i[31] ^ b_i[31];
  assign sc = c_i[31];
  assign aa = a_i[30:0];
  assign ab = b_i[30:0];
  assign ac = c_i[30:0];

  always_comb begin
    s1_spec_d.hit = 1'b1;
    s1_spec_d.val = '0;
    if (fcf_pkg::is_nan(c_i) && !c_i[22]) begin
      s1_spec_d.val = c_i | fcf_pkg::QuietBit;
    end else if (fcf_pkg::is_nan(a_i) && !a_i[22]) begin
      s1_spec_d.val = a_i | fcf_pkg::QuietBit;
    end else if (fcf_pkg::is_nan(b_i) && !b_i[22]) begin
      s1_spec_d.val = b_i | fcf_pkg::QuietBit;
    end else if (fcf_pkg::is_nan(c_i)) begin
      s1_spec_d.val = c_i;
    end else if (fcf_pkg::is_nan(a_i)) begin
      s1_spec_d.val = a_i;
    end else if (fcf_pkg::is_nan(b_i)) begin
      s1_spec_d.val = b_i;
    end else if ((aa == fcf_pkg::InfBits[30:0] && ab == '0) ||
                 (ab == fcf_pkg::InfBits[30:0] && aa == '0)) begin
      s1_spec_d.val = fcf_pkg::DefaultNan;
    end else if (aa == fcf_pkg::InfBits[30:0] || ab == fcf_pkg::InfBits[30:0]) begin
      s1_spec_d.val = (ac == fcf_pkg::InfBits[30:0] && sc != sp) ?
                      fcf_pkg::DefaultNan : {sp, fcf_pkg::InfBits[30:0]};
    end else if (ac == fcf_pkg::InfBits[30:0]) begin
      s1_spec_d.val = c_i;
    end else if ((aa == '0 || ab == '0) && ac == '0) begin
      s1_spec_d.val = (sp == sc) ? {sp, 31'b0} : 32'd0;
    end else begin
      s1_spec_d.hit = 1'b0;
    end
  end

  assign ma = {a_i[30:23] != 8'd0, a_i[22:0]};
  assign mb = {b_i[30:23] != 8'd0, b_i[22:0]};
  assign mc = {c_i[30:23] != 8'd0, c_i[22:0]};
  assign ea = (a_i[30:23] == 8'd0) ? -12'sd149 : $signed({4'b0, a_i[30:23]}) - 12'sd150;
  assign eb = (b_i[30:23] == 8'd0) ? -12'sd149 : $signed({4'b0, b_i[30:23]}) - 12'sd150;
  assign ec = (c_i[30:23] == 8'd0) ? -12'sd149 : $signed({4'b0, c_i[30:23]}) - 12'sd150;

  spec_t              s1_spec_q;
  logic [47:0]        s1_mp_q;
  logic signed [11:0] s1_ep_q, s1_ec_q;
  logic [23:0]        s1_mc_q;
  logic               s1_sp_q, s1_sc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_spec_q <= s1_spec_d;
      s1_mp_q   <= ma * mb;
      s1_ep_q   <= ea + eb;
      s1_mc_q   <= mc;
      s1_ec_q   <= ec;
      s1_sp_q   <= sp;
      s1_sc_q   <= sc;
    end
  end

  // stage 2: normalize both terms to bit 61, order by magnitude
  logic [5:0]         pp, pc;
  logic [63:0]        mpn, mcn;
  logic signed [11:0] epn, ecn;
  logic               pz, cz, prod_big;
  logic [63:0]        s2_big_d, s2_small_d;
  logic signed [11:0] s2_ebig_d, s2_d_d;

  assign pp  = fcf_pkg::msb64({16'b0, s1_mp_q});
  assign pc  = fcf_pkg::msb64({40'b0, s1_mc_q});
  assign mpn = {16'b0, s1_mp_q} << (6'd61 - pp);
  assign mcn = {40'b0, s1_mc_q} << (6'd61 - pc);
  assign epn = s1_ep_q - $signed({6'b0, 6'd61 - pp});
  assign ecn = s1_ec_q - $signed({6'b0, 6'd61 - pc});
  assign pz  = s1_mp_q == '0;
  assign cz  = s1_mc_q == '0;
  assign prod_big = cz || (!pz && (epn > ecn || (epn == ecn && mpn >= mcn)));

  always_comb begin
    if (prod_big) begin
      s2_big_d   = mpn;
      s2_ebig_d  = epn;
      s2_small_d = cz ? 64'd0 : mcn;
      s2_d_d     = cz ? 12'sd0 : epn - ecn;
    end else begin
      s2_big_d   = mcn;
      s2_ebig_d  = ecn;
      s2_small_d = pz ? 64'd0 : mpn;
      s2_d_d     = pz ? 12'sd0 : ecn - epn;
    end
  end

  spec_t              s2_spec_q;
  logic [63:0]        s2_big_q, s2_small_q;
  logic signed [11:0] s2_ebig_q, s2_d_q;
  logic               s2_sbig_q, s2_sub_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_spec_q  <= s1_spec_q;
      s2_big_q   <= s2_big_d;
      s2_small_q <= s2_small_d;
      s2_ebig_q  <= s2_ebig_d;
      s2_d_q     <= s2_d_d;
      s2_sbig_q  <= prod_big ? s1_sp_q : s1_sc_q;
      s2_sub_q   <= s1_sp_q != s1_sc_q;
    end
  end

  // stage 3: align with sticky, add or subtract
  logic [63:0] small_al, lost;

  always_comb begin
    lost = s2_small_q & ((64'd1 << s2_d_q[5:0]) - 64'd1);
    if (s2_d_q >= 12'sd63) begin
      small_al = {63'b0, s2_small_q != '0};
    end else begin
      small_al = (s2_small_q >> s2_d_q[5:0]) | {63'b0, lost != '0};
    end
  end

  spec_t              s3_spec_q;
  logic [63:0]        s3_sum_q;
  logic signed [11:0] s3_ebig_q;
  logic               s3_sbig_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_spec_q <= s2_spec_q;
      s3_sum_q  <= s2_sub_q ? s2_big_q - small_al : s2_big_q + small_al;
      s3_ebig_q <= s2_ebig_q;
      s3_sbig_q <= s2_sbig_q;
    end
  end

  // stage 4: normalize sum to bit 62, pick the rounding position
  logic [5:0]         ps;
  logic signed [11:0] e4, qt, q4, sh4;

  assign ps  = fcf_pkg::msb64(s3_sum_q);
  assign e4  = s3_ebig_q - $signed({6'b0, 6'd62 - ps});
  assign qt  = e4 + 12'sd39;
  assign q4  = (qt < -12'sd149) ? -12'sd149 : qt;
  assign sh4 = q4 - e4;

  spec_t              s4_spec_q;
  logic [63:0]        s4_sig_q;
  logic signed [11:0] s4_q_q;
  logic [5:0]         s4_sh_q;
  logic               s4_shbig_q, s4_zero_q, s4_sign_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_spec_q  <= s3_spec_q;
      s4_sig_q   <= s3_sum_q << (6'd62 - ps);
      s4_q_q     <= q4;
      s4_sh_q    <= sh4[5:0];
      s4_shbig_q <= sh4 >= 12'sd64;
      s4_zero_q  <= s3_sum_q == '0;
      s4_sign_q  <= s3_sbig_q;
    end
  end

  // stage 5: round and pack
  logic [63:0]        shifted;
  logic               rbit, sticky;
  logic [24:0]        mant;
  logic signed [11:0] biased;
  logic [39:0]        packed_b;
  logic [31:0]        z_d;

  always_comb begin
    shifted = s4_sig_q >> s4_sh_q;
    rbit    = s4_sig_q[s4_sh_q - 6'd1];
    sticky  = (s4_sig_q & ((64'd1 << (s4_sh_q - 6'd1)) - 64'd1)) != '0;
    if (s4_shbig_q) begin
      mant = '0;
    end else begin
      mant = shifted[24:0] + {24'b0, rbit && (sticky || shifted[0])};
    end
    biased   = s4_q_q + 12'sd149;
    packed_b = ({28'b0, biased[11:0]} << 23) + {15'b0, mant};
    if (s4_spec_q.hit) begin
      z_d = s4_spec_q.val;
    end else if (s4_zero_q) begin
      z_d = '0;
    end else if (biased > 12'sd254 || packed_b >= {8'b0, fcf_pkg::InfBits}) begin
      z_d = {s4_sign_q, fcf_pkg::InfBits[30:0]};
    end else begin
      z_d = {s4_sign_q, packed_b[30:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_o <= z_d;
    end
  end

endmodule

>>> sv/fast_cosine_float32_unit.sv
// Top level of the pipelined fast float32 cosine unit.
//
// Requests arrive on x_bits_i with in_valid_i / in_ready_o; results leave
// on cos_bits_o and needs_accurate_path_o with out_valid_o / out_ready_i.
// A request is taken on any edge where valid and ready are both high.
// One request per cycle is taken and one result per cycle is delivered
// unless the output stalls. The path to out_valid_o holds seven
// dependent fused multiply-adds of five stages each, the first loaded at
// the accepting edge, one rounding stage and the output register.
// The whole pipeline advances together; when the output register holds
// an untaken result, the pipe freezes and in_ready_o drops, so nothing
// is lost or repeated. No payload is reset; reset clears only the valid
// bits. needs_accurate_path_o flags |x| >= 2^15 or infinity, for which
// cos_bits_o is the inaccurate fast-path value.
`timescale 1ns / 1ps
module fast_cosine_float32_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] x_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] cos_bits_o,
  output logic        needs_accurate_path_o
);

  logic en;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic [fcf_pkg::PipeDepth-1:0] vld_q;
  logic                          out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[fcf_pkg::PipeDepth-2:0], in_valid_i};
      out_valid_q <= vld_q[fcf_pkg::PipeDepth-1];
    end
  end

  logic flag;
  assign flag = {1'b0, x_bits_i[30:0]} >= fcf_pkg::RangeLimit &&
                {1'b0, x_bits_i[30:0]} <= fcf_pkg::InfBits;

  logic [31:0] za, zb, zc, zd, ze, zf, zg, zh;
  logic [31:0] n_q;
  logic [31:0] x_dly_q  [11];
  logic [31:0] nb_dly_q [5];
  logic [31:0] r_dly_q  [10];
  logic [31:0] odd_dly_q[30];
  logic        flag_dly_q[fcf_pkg::PipeDepth];

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q           <= fcf_pkg::round_away(za);
      x_dly_q[0]    <= x_bits_i;
      nb_dly_q[0]   <= zb;
      r_dly_q[0]    <= zd;
      odd_dly_q[0]  <= fcf_pkg::odd_mask(n_q);
      flag_dly_q[0] <= flag;
      for (int i = 1; i < 11; i++) x_dly_q[i] <= x_dly_q[i-1];
      for (int i = 1; i < 5; i++) nb_dly_q[i] <= nb_dly_q[i-1];
      for (int i = 1; i < 10; i++) r_dly_q[i] <= r_dly_q[i-1];
      for (int i = 1; i < 30; i++) odd_dly_q[i] <= odd_dly_q[i-1];
      for (int i = 1; i < fcf_pkg::PipeDepth; i++) flag_dly_q[i] <= flag_dly_q[i-1];
      cos_bits_o            <= zh ^ odd_dly_q[29];
      needs_accurate_path_o <= flag_dly_q[fcf_pkg::PipeDepth-1];
    end
  end

  fcf_fma u_fma_n (
    .clk_i, .en_i(en), .a_i(x_bits_i), .b_i(fcf_pkg::InvPi),
    .c_i(fcf_pkg::HalfBits), .z_o(za)
  );

  fcf_fma u_fma_half (
    .clk_i, .en_i(en), .a_i(n_q), .b_i(fcf_pkg::OneBits),
    .c_i(fcf_pkg::MHalfBits), .z_o(zb)
  );

  fcf_fma u_fma_red_hi (
    .clk_i, .en_i(en), .a_i(zb ^ fcf_pkg::SignBit), .b_i(fcf_pkg::PiHi),
    .c_i(x_dly_q[10]), .z_o(zc)
  );

  fcf_fma u_fma_red_lo (
    .clk_i, .en_i(en), .a_i(nb_dly_q[4] ^ fcf_pkg::SignBit), .b_i(fcf_pkg::PiLo),
    .c_i(zc), .z_o(zd)
  );

  fcf_fma u_fma_r2 (
    .clk_i, .en_i(en), .a_i(zd), .b_i(zd), .c_i(fcf_pkg::MZeroBits), .z_o(ze)
  );

  fcf_fma u_fma_r3 (
    .clk_i, .en_i(en), .a_i(ze), .b_i(r_dly_q[4]), .c_i(fcf_pkg::MZeroBits), .z_o(zf)
  );

  fcf_fma u_fma_poly (
    .clk_i, .en_i(en), .a_i(ze), .b_i(fcf_pkg::Coef1), .c_i(fcf_pkg::Coef0), .z_o(zg)
  );

  fcf_fma u_fma_out (
    .clk_i, .en_i(en), .a_i(zf), .b_i(zg), .c_i(r_dly_q[9]), .z_o(zh)
  );

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the fast float32 cosine unit, with its own float32 predictor.
`timescale 1ns / 1ps
module testbench;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] x_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [31:0] cos_bits;
  logic        needs_accurate;

  typedef struct packed {
    logic [31:0] cos;
    logic        flag;
  } cos_result_t;

  cos_result_t cos_expected_q[$];
  int unsigned err_count = 0;
  int unsigned checked = 0;
  int unsigned sent = 0;
  int unsigned flagged = 0;
  int unsigned cycle = 0;
  bit          idle_on = 1'b1;
  int          ready_hold = 0;

  localparam int unsigned CycleLimit = 400000;

  fast_cosine_float32_unit dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .x_bits_i              (x_bits),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .cos_bits_o            (cos_bits),
    .needs_accurate_path_o (needs_accurate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit nan32(logic [31:0] v);
    return v[30:0] > 31'h7F80_0000;
  endfunction

  function automatic int hi_bit(longint unsigned v);
    int p;
    p = 0;
    while (v > 64'd1) begin
      v = v >> 1;
      p++;
    end
    return p;
  endfunction

  function automatic logic [31:0] pack_f32(logic [31:0] sign, int e, longint unsigned sig);
    int              p;
    int              q;
    int              sh;
    longint unsigned mant;
    longint unsigned rem;
    longint unsigned half;
    longint unsigned b;
    p = hi_bit(sig);
    sig = sig << (62 - p);
    e = e - (62 - p);
    q = e + 39;
    if (q < -149) q = -149;
    sh = q - e;
    if (sh >= 64) begin
      mant = 0;
    end else begin
      rem  = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      mant = sig >> sh;
      if (rem > half || (rem == half && mant[0])) mant++;
    end
    if (q + 149 > 254) return sign | fcf_pkg::InfBits;
    b = (longint'(q + 149) << 23) + mant;
    if (b >= 64'h7F80_0000) return sign | fcf_pkg::InfBits;
    return sign | b[31:0];
  endfunction

  function automatic void split_f32(logic [31:0] v, output longint unsigned m, output int e);
    if (v[30:23] == 8'd0) begin
      m = v[22:0];
      e = -149;
    end else begin
      m = {1'b1, v[22:0]};
      e = int'(v[30:23]) - 150;
    end
  endfunction

  // a * b + c with a single rounding
  function automatic logic [31:0] fma32(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [31:0]     sp;
    logic [31:0]     sc;
    logic [31:0]     sbig;
    logic [31:0]     ssml;
    longint unsigned ma, mb, mc, mp, big, sml, sum, lost;
    int              ea, eb, ec, ep, ebig, d, p;
    sp = (a ^ b) & fcf_pkg::SignBit;
    sc = c & fcf_pkg::SignBit;
    if (nan32(c) && !c[22]) return c | fcf_pkg::QuietBit;
    if (nan32(a) && !a[22]) return a | fcf_pkg::QuietBit;
    if (nan32(b) && !b[22]) return b | fcf_pkg::QuietBit;
    if (nan32(c)) return c;
    if (nan32(a)) return a;
    if (nan32(b)) return b;
    if ((a[30:0] == fcf_pkg::InfBits[30:0] && b[30:0] == 0) ||
        (b[30:0] == fcf_pkg::InfBits[30:0] && a[30:0] == 0)) return fcf_pkg::DefaultNan;
    if (a[30:0] == fcf_pkg::InfBits[30:0] || b[30:0] == fcf_pkg::InfBits[30:0]) begin
      if (c[30:0] == fcf_pkg::InfBits[30:0] && sc != sp) return fcf_pkg::DefaultNan;
      return sp | fcf_pkg::InfBits;
    end
    if (c[30:0] == fcf_pkg::InfBits[30:0]) return c;
    split_f32(a, ma, ea);
    split_f32(b, mb, eb);
    split_f32(c, mc, ec);
    mp = ma * mb;
    ep = ea + eb;
    if (mp == 0 && mc == 0) return (sp == sc) ? sp : 32'd0;
    if (mp == 0) return c;
    if (mc == 0) return pack_f32(sp, ep, mp);
    p = hi_bit(mp);
    mp = mp << (61 - p);
    ep = ep - (61 - p);
    p = hi_bit(mc);
    mc = mc << (61 - p);
    ec = ec - (61 - p);
    if (ep > ec || (ep == ec && mp >= mc)) begin
      big = mp; ebig = ep; sbig = sp; sml = mc; ssml = sc; d = ep - ec;
    end else begin
      big = mc; ebig = ec; sbig = sc; sml = mp; ssml = sp; d = ec - ep;
    end
    if (d >= 63) begin
      sml = 1;
    end else if (d > 0) begin
      lost = sml & ((64'd1 << d) - 64'd1);
      sml = (sml >> d) | ((lost != 0) ? 64'd1 : 64'd0);
    end
    sum = (sbig == ssml) ? big + sml : big - sml;
    if (sum == 0) return 32'd0;
    return pack_f32(sbig, ebig, sum);
  endfunction

  function automatic logic [31:0] rint_away(logic [31:0] v);
    logic [31:0] ax;
    int unsigned be;
    int unsigned k;
    ax = {1'b0, v[30:0]};
    be = ax[30:23];
    if (nan32(v)) return v | fcf_pkg::QuietBit;
    if (be >= 150) return v;
    if (be < 126) return v & fcf_pkg::SignBit;
    if (be == 126) return (v & fcf_pkg::SignBit) | fcf_pkg::OneBits;
    k = 150 - be;
    ax = ax + (32'd1 << (k - 1));
    ax = ax & ~((32'd1 << k) - 32'd1);
    return (v & fcf_pkg::SignBit) | ax;
  endfunction

  // odd n flips the sign; int32 conversion saturates
  function automatic logic [31:0] parity_sign(logic [31:0] n);
    int unsigned be;
    logic [23:0] m;
    if (nan32(n)) return '0;
    if ({1'b0, n[30:0]} >= 32'h4F00_0000) return n[31] ? 32'd0 : fcf_pkg::SignBit;
    be = n[30:23];
    if (be < 127 || be > 150) return '0;
    m = {1'b1, n[22:0]};
    return {m[150 - be], 31'b0};
  endfunction

  function automatic cos_result_t predict_cos(logic [31:0] x);
    cos_result_t res;
    logic [31:0] n, flip, r, r2, r3, y;
    n    = rint_away(fma32(x, fcf_pkg::InvPi, fcf_pkg::HalfBits));
    flip = parity_sign(n);
    n    = fma32(n, fcf_pkg::OneBits, fcf_pkg::MHalfBits);
    r    = fma32(n ^ fcf_pkg::SignBit, fcf_pkg::PiHi, x);
    r    = fma32(n ^ fcf_pkg::SignBit, fcf_pkg::PiLo, r);
    r2   = fma32(r, r, fcf_pkg::MZeroBits);
    r3   = fma32(r2, r, fcf_pkg::MZeroBits);
    y    = fma32(r2, fcf_pkg::Coef1, fcf_pkg::Coef0);
    y    = fma32(r3, y, r);
    res.cos  = y ^ flip;
    res.flag = ({1'b0, x[30:0]} >= fcf_pkg::RangeLimit) &&
               ({1'b0, x[30:0]} <= fcf_pkg::InfBits);
    return res;
  endfunction

  task automatic send_angle(logic [31:0] v);
    in_valid <= 1'b1;
    x_bits   <= v;
    do @(posedge clk); while (!in_ready);
    cos_expected_q.push_back(predict_cos(v));
    sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] random_angle();
    int unsigned sel;
    logic [31:0] v;
    sel = $urandom_range(0, 99);
    v = $urandom;
    if (sel < 40) v[30:23] = 8'($urandom_range(110, 150));
    else if (sel < 60) v[30:23] = 8'($urandom_range(127, 142));
    else if (sel < 70) v[30:16] = 15'h4700 + 15'($urandom_range(0, 31)) - 15'd16;
    else if (sel < 80) v[30:23] = 8'($urandom_range(0, 3));
    else if (sel < 85) v[30:23] = 8'hFF;
    else if (sel < 90) v[30:23] = 8'($urandom_range(143, 160));
    return v;
  endfunction

  task automatic test_directed();
    logic [31:0] pts[$];
    pts = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
            32'h7FC0_0000, 32'h7F80_0001, 32'hFFA5_5AA5, 32'h7FFF_FFFF,
            32'h4700_0000, 32'hC700_0000, 32'h46FF_FFFF, 32'h7F7F_FFFF,
            32'hFF7F_FFFF, 32'h0000_0001, 32'h807F_FFFF, 32'h0080_0000,
            32'h4049_0FDB, 32'h3FC9_0FDB, 32'h3F80_0000, 32'hBF80_0000,
            32'h4F49_0FDB, 32'hCF49_0FDB, 32'h5000_0000, 32'hD000_0000,
            32'h4B80_0000};
    foreach (pts[i]) send_angle(pts[i]);
  endtask

  task automatic test_random(int unsigned count);
    repeat (count) send_angle(random_angle());
  endtask

  task automatic test_streaming(int unsigned count);
    idle_on = 1'b0;
    repeat (count) send_angle(random_angle());
  endtask

  always @(posedge clk) begin
    if (!idle_on) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= (ready_hold == 1);
    end else if ($urandom_range(0, 4) == 0) begin
      ready_hold <= $urandom_range(1, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cos_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (cos_expected_q.size() == 0) begin
        $error("result with nothing outstanding: cos_bits %h", cos_bits);
        err_count++;
      end else begin
        exp_r = cos_expected_q.pop_front();
        checked++;
        if (exp_r.flag) flagged++;
        if (cos_bits !== exp_r.cos) begin
          $error("cos_bits expected %h actual %h", exp_r.cos, cos_bits);
          err_count++;
        end
        if (needs_accurate !== exp_r.flag) begin
          $error("needs_accurate_path expected %b actual %b", exp_r.flag, needs_accurate);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(900);
    test_streaming(200);
    in_valid <= 1'b0;
    while (cos_expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("sent %0d angles, checked %0d results, %0d flagged for accurate path",
             sent, checked, flagged);
    $display("covered specials, range edge, subnormals, saturation, stalls and streaming");
    if (err_count == 0 && cos_expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
